[rtl/core/weighted_vruntime_scheduler_defines.svh]
// ----------------------------------------------------------------------------
// Weighted vruntime scheduler - assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_VRUNTIME_SCHEDULER_DEFINES_SVH
`define WEIGHTED_VRUNTIME_SCHEDULER_DEFINES_SVH

// Check a property on every clock edge out of reset.
`define WVS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition follows a trigger in the next cycle.
`define WVS_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error(msg);

`endif

[rtl/core/wvs_pkg.sv]
// ----------------------------------------------------------------------------
// wvs_pkg
// Types, sizes and codes shared by the vruntime scheduler modules.
// ----------------------------------------------------------------------------
package wvs_pkg;

    localparam int MAX_TASKS       = 32;
    localparam int NUM_LEVELS      = 5;
    localparam int NUM_WEIGHT_REGS = 5;
    localparam int NUM_REGS        = NUM_WEIGHT_REGS + 1;

    localparam int AW        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW        = $clog2(MAX_TASKS + 1);
    localparam int PADDR_W   = $clog2(4 * NUM_REGS);
    localparam int RIDX_W    = PADDR_W - 2;
    localparam int WIDX_W    = $clog2(NUM_WEIGHT_REGS);

    localparam int ID_W      = 8;
    localparam int LVL_W     = 3;
    localparam int RT_W      = 32;
    localparam int WEIGHT_W  = 10;
    localparam int SLICE_W   = 8;
    localparam int CHARGE_W  = WEIGHT_W + SLICE_W;

    // highest level that owns a weight register
    localparam int LVL_TOP_I = (NUM_LEVELS - 1 < NUM_WEIGHT_REGS - 1) ?
                               (NUM_LEVELS - 1) : (NUM_WEIGHT_REGS - 1);
    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LVL_TOP_I);

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET [NUM_WEIGHT_REGS] =
        '{10'd164, 10'd205, 10'd256, 10'd320, 10'd400};
    localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd1;

    // register indexes on the config port
    localparam logic [RIDX_W-1:0] REG_WEIGHT0 = RIDX_W'(0);
    localparam logic [RIDX_W-1:0] REG_SLICE   = RIDX_W'(NUM_WEIGHT_REGS);

    // item kinds
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [LVL_W-1:0] level;
        logic [RT_W-1:0]  runtime;
    } t_entry;

    typedef struct packed {
        logic             served_valid;
        logic [ID_W-1:0]  served_id;
        logic [RT_W-1:0]  served_runtime;
        logic             error_flag;
    } t_result;

    typedef struct packed {
        logic [NUM_WEIGHT_REGS-1:0][WEIGHT_W-1:0] weight;
        logic [SLICE_W-1:0]                       slice;
    } t_cfg;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        t_entry        wdata;
        logic [AW-1:0] raddr;
    } t_mem_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SUM,
        S_WALK,
        S_PLACE,
        S_DONE
    } t_state;

    function automatic logic [LVL_W-1:0] clamp_level(input logic [LVL_W-1:0] lvl);
        return (lvl > LVL_TOP) ? LVL_TOP : lvl;
    endfunction

endpackage

[rtl/core/wvs_qmem.sv]
// ----------------------------------------------------------------------------
// wvs_qmem
// Queue entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wvs_qmem
    import wvs_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rdata
);

    t_entry mem [MAX_TASKS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= mem[i_req.raddr];
    end

endmodule

[rtl/core/wvs_ctrl.sv]
// ----------------------------------------------------------------------------
// wvs_ctrl
// Queue sequencer: pops the head, charges it, and walks the ring backward
// from the tail to insert an entry in runtime order. Holds the result word.
// ----------------------------------------------------------------------------
`include "weighted_vruntime_scheduler_defines.svh"

module wvs_ctrl
    import wvs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_kind,
    input  logic [ID_W-1:0]  i_task_id,
    input  logic [LVL_W-1:0] i_level,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_result          o_result,
    output t_mem_req         o_mem,
    input  t_entry           i_mem_rdata
);

    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TASKS);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);
    localparam logic [CW-1:0] CNT_TWO = CW'(2);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_head,  n_head;
    logic [CW-1:0]       r_k,     n_k;
    t_entry              r_new,   n_new;
    logic [RT_W-1:0]     r_rt_old, n_rt_old;
    logic [CHARGE_W-1:0] r_charge, n_charge;
    t_result             r_res,   n_res;
    logic                r_out_valid, n_out_valid;
    t_result             r_out,   n_out;

    logic                accept;
    logic [RT_W:0]       sum;
    logic [WEIGHT_W-1:0] head_weight;

    // logical queue position to ring address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] pos);
        logic [AW:0] s;
        s = {1'b0, head} + (AW+1)'(pos);
        if (s >= (AW+1)'(MAX_TASKS)) begin
            s = s - (AW+1)'(MAX_TASKS);
        end
        return s[AW-1:0];
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    assign head_weight = i_cfg.weight[WIDX_W'(i_mem_rdata.level)];
    assign sum         = {1'b0, r_rt_old} + (RT_W+1)'(r_charge);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_ADD) begin
                        if (r_count == CNT_MAX) begin
                            n_state = S_DONE;
                        end else if (r_count == '0) begin
                            n_state = S_PLACE;
                        end else begin
                            n_state = S_WALK;
                        end
                    end else begin
                        n_state = (r_count == '0) ? S_DONE : S_POP;
                    end
                end
            end
            S_POP: n_state = S_SUM;
            S_SUM: n_state = (r_count == '0) ? S_PLACE : S_WALK;
            S_WALK: begin
                if (i_mem_rdata.runtime > r_new.runtime) begin
                    n_state = (r_k == CNT_ONE) ? S_PLACE : S_WALK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PLACE: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count     = r_count;
        n_head      = r_head;
        n_k         = r_k;
        n_new       = r_new;
        n_rt_old    = r_rt_old;
        n_charge    = r_charge;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_mem       = '0;
        o_mem.raddr = r_head;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res = '0;
                    if (i_kind == KIND_ADD) begin
                        n_new.id      = i_task_id;
                        n_new.level   = clamp_level(i_level);
                        n_new.runtime = '0;
                        n_k           = r_count;
                        n_res.error_flag = (r_count == CNT_MAX);
                        // fetch the tail entry to start the walk
                        o_mem.raddr   = phys(r_head, r_count - CNT_ONE);
                    end else begin
                        n_res.error_flag = (r_count == '0);
                    end
                end
            end
            S_POP: begin
                n_new.id    = i_mem_rdata.id;
                n_new.level = i_mem_rdata.level;
                n_rt_old    = i_mem_rdata.runtime;
                n_charge    = CHARGE_W'(i_cfg.slice) * CHARGE_W'(head_weight);
                n_head      = (r_head == AW'(MAX_TASKS - 1)) ? '0 : r_head + AW'(1);
                n_count     = r_count - CNT_ONE;
            end
            S_SUM: begin
                n_new.runtime        = sum[RT_W] ? '1 : sum[RT_W-1:0];
                n_res.served_valid   = 1'b1;
                n_res.served_id      = r_new.id;
                n_res.served_runtime = sum[RT_W] ? '1 : sum[RT_W-1:0];
                n_k                  = r_count;
                o_mem.raddr          = phys(r_head, r_count - CNT_ONE);
            end
            S_WALK: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = phys(r_head, r_k);
                if (i_mem_rdata.runtime > r_new.runtime) begin
                    // shift the larger entry one slot toward the tail
                    o_mem.wdata = i_mem_rdata;
                    n_k         = r_k - CNT_ONE;
                    o_mem.raddr = phys(r_head, r_k - CNT_TWO);
                end else begin
                    o_mem.wdata = r_new;
                    n_count     = r_count + CNT_ONE;
                end
            end
            S_PLACE: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = phys(r_head, r_k);
                o_mem.wdata = r_new;
                n_count     = r_count + CNT_ONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_new    <= n_new;
        r_rt_old <= n_rt_old;
        r_charge <= n_charge;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    `WVS_ASSERT(a_count_bound, r_count <= CNT_MAX, "queue count above capacity")
    `WVS_ASSERT(a_pop_nonempty, (r_state != S_POP) || (r_count != '0), "pop from empty queue")
    `WVS_ASSERT(a_walk_pos, (r_state != S_WALK) || (r_k != '0), "walk below queue head")
    `WVS_ASSERT(a_res_excl, !(r_out_valid && r_out.served_valid && r_out.error_flag), "served word flagged as error")
    `WVS_ASSERT_NEXT(a_accept_busy, accept, r_state != S_IDLE, "accepted word left sequencer idle")

endmodule

[rtl/core/weighted_vruntime_scheduler.sv]
// ----------------------------------------------------------------------------
// weighted_vruntime_scheduler
// Ready queue of tasks kept in ascending virtual runtime order.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tuser is the kind (0 add, 1 tick); s_axis_tdata holds
// task_id and nice_level. Every accepted word yields one result word on the
// master stream: tuser carries served_valid and error_flag, tdata the served
// id and its updated Q24.8 runtime.
// Weights and slice length sit behind the APB port; write them only while the
// block is idle.
// The insertion walks the queue entries one per cycle through the one read port
// and one write port of the entry memory, so an item can take longer the deeper
// the queue in use. Full-queue adds and empty-queue ticks skip the walk and
// finish with error_flag set.
// One item is in flight at a time; the next is taken once the previous result
// sits in the output register, even if the receiver has not taken it yet.
// A stalled receiver holds that result and blocks only the following result.
// Reset empties the queue and loads default weights; memory is not cleared.
// ----------------------------------------------------------------------------
module weighted_vruntime_scheduler
    import wvs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // stream in
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [15:0]        s_axis_tdata,  // [7:0] task_id, [10:8] nice_level
    input  logic               s_axis_tuser,  // [0] kind
    // stream out
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [39:0]        m_axis_tdata,  // [7:0] served_id, [39:8] served_runtime
    output logic [1:0]         m_axis_tuser,  // [0] served_valid, [1] error_flag
    // config
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [WEIGHT_W-1:0] r_weight [NUM_WEIGHT_REGS];
    logic [SLICE_W-1:0]  r_slice;
    logic [RIDX_W-1:0]   reg_idx;
    logic                cfg_wr;
    t_cfg                cfg;
    t_result             result;
    t_mem_req            mem_req;
    t_entry              mem_rdata;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WEIGHT_REGS; i++) begin
                r_weight[i] <= WEIGHT_RESET[i];
            end
            r_slice <= SLICE_RESET;
        end else if (cfg_wr) begin
            if (reg_idx < REG_SLICE) begin
                r_weight[WIDX_W'(reg_idx)] <= pwdata[WEIGHT_W-1:0];
            end else if (reg_idx == REG_SLICE) begin
                r_slice <= pwdata[SLICE_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx < REG_SLICE) begin
            prdata = 32'(r_weight[WIDX_W'(reg_idx)]);
        end else if (reg_idx == REG_SLICE) begin
            prdata = 32'(r_slice);
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_WEIGHT_REGS; i++) begin
            cfg.weight[i] = r_weight[i];
        end
        cfg.slice = r_slice;
    end

    wvs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_task_id   (s_axis_tdata[7:0]),
        .i_level     (s_axis_tdata[10:8]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (result),
        .o_mem       (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    wvs_qmem u_qmem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign m_axis_tdata = {result.served_runtime, result.served_id};
    assign m_axis_tuser = {result.error_flag, result.served_valid};

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - weighted vruntime scheduler testbench
// Drives add and tick words into the ready queue and checks every result word
// against a cycle-free model of the queue kept in the bench. A short directed
// table covers the empty tick, level clamping and the reset weights; random
// traffic under several weight and slice settings then fills the queue to full.
// ----------------------------------------------------------------------------
module tb;
    import wvs_pkg::*;

    localparam int RAND_PHASES     = 6;
    localparam int RAND_PER_PHASE  = 250;
    localparam int ADD_PCT         = 6;
    localparam int PRESSURE_CYCLES = 400;
    localparam int IDLE_SETTLE     = 45;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SIM_LIMIT_NS    = 20_000_000;
    localparam int REG_UNUSED      = 7;

    localparam t_result RES_ZERO  = '0;
    localparam t_result RES_EMPTY = '{1'b0, 8'h00, 32'h0, 1'b1};

    typedef struct packed {
        logic             kind;
        logic [ID_W-1:0]  id;
        logic [LVL_W-1:0] level;
        logic             typed;
        t_result          res;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata;   // [7:0] task_id, [10:8] nice_level
    logic               s_axis_tuser;   // [0] kind
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [39:0]        m_axis_tdata;   // [7:0] served_id, [39:8] served_runtime
    logic [1:0]         m_axis_tuser;   // [0] served_valid, [1] error_flag
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    weighted_vruntime_scheduler uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // bench copy of the queue and its settings
    logic [ID_W-1:0]     q_id  [MAX_TASKS];
    logic [LVL_W-1:0]    q_lvl [MAX_TASKS];
    logic [RT_W-1:0]     q_rt  [MAX_TASKS];
    int                  q_len = 0;
    logic [WEIGHT_W-1:0] weight_cfg [NUM_WEIGHT_REGS] = '{10'd164, 10'd205, 10'd256, 10'd320,
                                                          10'd400};
    logic [SLICE_W-1:0]  slice_cfg = 8'd1;

    t_result pending_results [$];

    int  fails         = 0;
    int  words_in      = 0;
    int  results_seen  = 0;
    int  ticks_served  = 0;
    int  flagged       = 0;
    int  saturated     = 0;
    bit  pressure_req  = 0;
    bit  pressure_done = 0;

    t_dir_row dir_rows [22] = '{
        '{KIND_TICK, 8'h00, 3'd0, 1'b1, RES_EMPTY},
        '{KIND_ADD,  8'hFF, 3'd7, 1'b1, RES_ZERO},
        '{KIND_TICK, 8'h3C, 3'd2, 1'b1, '{1'b1, 8'hFF, 32'd400, 1'b0}},
        '{KIND_TICK, 8'h00, 3'd0, 1'b1, '{1'b1, 8'hFF, 32'd800, 1'b0}},
        '{KIND_TICK, 8'hC3, 3'd7, 1'b1, '{1'b1, 8'hFF, 32'd1200, 1'b0}},
        '{KIND_ADD,  8'h00, 3'd0, 1'b1, RES_ZERO},
        '{KIND_TICK, 8'h00, 3'd0, 1'b1, '{1'b1, 8'h00, 32'd164, 1'b0}},
        '{KIND_ADD,  8'h80, 3'd5, 1'b1, RES_ZERO},
        '{KIND_ADD,  8'h7F, 3'd6, 1'b1, RES_ZERO},
        '{KIND_TICK, 8'h00, 3'd0, 1'b1, '{1'b1, 8'h80, 32'd400, 1'b0}},
        '{KIND_TICK, 8'hFF, 3'd4, 1'b1, '{1'b1, 8'h7F, 32'd400, 1'b0}},
        '{KIND_ADD,  8'h01, 3'd1, 1'b1, RES_ZERO},
        '{KIND_ADD,  8'h02, 3'd2, 1'b1, RES_ZERO},
        '{KIND_ADD,  8'h03, 3'd3, 1'b1, RES_ZERO},
        '{KIND_TICK, 8'h00, 3'd0, 1'b0, RES_ZERO},
        '{KIND_TICK, 8'h00, 3'd0, 1'b0, RES_ZERO},
        '{KIND_TICK, 8'h00, 3'd0, 1'b0, RES_ZERO},
        '{KIND_TICK, 8'hAA, 3'd5, 1'b0, RES_ZERO},
        '{KIND_TICK, 8'h55, 3'd1, 1'b0, RES_ZERO},
        '{KIND_TICK, 8'h00, 3'd0, 1'b0, RES_ZERO},
        '{KIND_ADD,  8'h55, 3'd4, 1'b1, RES_ZERO},
        '{KIND_TICK, 8'h00, 3'd0, 1'b0, RES_ZERO}
    };

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic logic [PADDR_W-1:0] reg_addr(input int idx);
        return PADDR_W'(idx * 4);
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] have);
        if (have !== want) begin
            $error("%s: expected %0h, got %0h", name, want, have);
            fails++;
        end
    endfunction

    // insert behind every entry whose runtime is equal or smaller
    function automatic void enqueue_task(input logic [ID_W-1:0] id,
                                         input logic [LVL_W-1:0] lvl,
                                         input logic [RT_W-1:0] rt);
        int pos;
        pos = 0;
        while (pos < q_len && q_rt[pos] <= rt) pos++;
        for (int k = q_len; k > pos; k--) begin
            q_id[k]  = q_id[k-1];
            q_lvl[k] = q_lvl[k-1];
            q_rt[k]  = q_rt[k-1];
        end
        q_id[pos]  = id;
        q_lvl[pos] = lvl;
        q_rt[pos]  = rt;
        q_len++;
    endfunction

    function automatic t_result schedule_step(input logic kind, input logic [ID_W-1:0] id,
                                              input logic [LVL_W-1:0] lvl);
        t_result          res;
        logic [ID_W-1:0]  head_id;
        logic [LVL_W-1:0] head_lvl;
        logic [RT_W-1:0]  head_rt;
        logic [63:0]      total;
        res = RES_ZERO;
        if (kind == KIND_ADD) begin
            if (q_len >= MAX_TASKS)
                res.error_flag = 1'b1;
            else
                enqueue_task(id, (lvl > LVL_TOP) ? LVL_TOP : lvl, '0);
        end else if (q_len == 0) begin
            res.error_flag = 1'b1;
        end else begin
            head_id  = q_id[0];
            head_lvl = q_lvl[0];
            head_rt  = q_rt[0];
            for (int k = 1; k < q_len; k++) begin
                q_id[k-1]  = q_id[k];
                q_lvl[k-1] = q_lvl[k];
                q_rt[k-1]  = q_rt[k];
            end
            q_len--;
            total = 64'(head_rt) + 64'(slice_cfg) * 64'(weight_cfg[head_lvl]);
            if (total > 64'hFFFF_FFFF)
                total = 64'hFFFF_FFFF;
            enqueue_task(head_id, head_lvl, total[31:0]);
            res.served_valid   = 1'b1;
            res.served_id      = head_id;
            res.served_runtime = total[31:0];
        end
        return res;
    endfunction

    task automatic send_word(input logic kind, input logic [ID_W-1:0] id,
                             input logic [LVL_W-1:0] lvl, input logic typed,
                             input t_result typed_res);
        int      gap;
        int      roll;
        t_result res;
        gap  = 0;
        roll = $urandom_range(0, 99);
        if ((words_in % 200) >= 40) begin
            if (roll >= 90)
                gap = $urandom_range(8, 40);
            else if (roll >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, lvl, id};
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_in++;
        res = schedule_step(kind, id, lvl);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // drop valid and let every outstanding result come back
    task automatic wait_idle;
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            fails++;
            pending_results.delete();
        end
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input int idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(idx);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < NUM_WEIGHT_REGS)
            weight_cfg[idx] = val[WEIGHT_W-1:0];
        else if (idx == int'(REG_SLICE))
            slice_cfg = val[SLICE_W-1:0];
    endtask

    task automatic check_registers;
        logic [31:0] want;
        for (int idx = 0; idx <= int'(REG_SLICE); idx++) begin
            want = (idx < NUM_WEIGHT_REGS) ? 32'(weight_cfg[idx]) : 32'(slice_cfg);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= reg_addr(idx);
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            compare_field("prdata", want, prdata);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic load_config(input logic [31:0] w0, input logic [31:0] w1,
                               input logic [31:0] w2, input logic [31:0] w3,
                               input logic [31:0] w4, input logic [31:0] sl);
        wait_idle();
        cfg_write(int'(REG_WEIGHT0),     w0);
        cfg_write(int'(REG_WEIGHT0) + 1, w1);
        cfg_write(int'(REG_WEIGHT0) + 2, w2);
        cfg_write(int'(REG_WEIGHT0) + 3, w3);
        cfg_write(int'(REG_WEIGHT0) + 4, w4);
        cfg_write(int'(REG_SLICE),       sl);
        check_registers();
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        int roll;
        int hold;
        int rx_cycle;
        rx_cycle = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            roll = $urandom_range(0, 99);
            if (pressure_req && !pressure_done) begin
                m_axis_tready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge i_clk);
                pressure_done = 1;
                m_axis_tready <= 1'b1;
            end else if ((rx_cycle % 1000) < 200) begin
                m_axis_tready <= 1'b1;
            end else if (roll < 65) begin
                m_axis_tready <= 1'b1;
            end else if (roll < 95) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b0;
                hold = $urandom_range(10, 40);
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.served_valid   = m_axis_tuser[0];
            got.error_flag     = m_axis_tuser[1];
            got.served_id      = m_axis_tdata[7:0];
            got.served_runtime = m_axis_tdata[39:8];
            results_seen++;
            if (got.served_valid === 1'b1) ticks_served++;
            if (got.error_flag === 1'b1) flagged++;
            if (got.served_valid === 1'b1 && got.served_runtime === 32'hFFFF_FFFF) saturated++;
            if (pending_results.size() == 0) begin
                $error("result word with nothing outstanding: tuser %0h tdata %0h",
                       m_axis_tuser, m_axis_tdata);
                fails++;
            end else begin
                want = pending_results.pop_front();
                compare_field("served_valid",   32'(want.served_valid),   32'(got.served_valid));
                compare_field("served_id",      32'(want.served_id),      32'(got.served_id));
                compare_field("served_runtime", want.served_runtime,      got.served_runtime);
                compare_field("error_flag",     32'(want.error_flag),     32'(got.error_flag));
            end
        end
    end

    initial begin
        #(SIM_LIMIT_NS);
        $display("tb: errors");
        $finish;
    end

    initial begin
        logic             kind;
        logic [ID_W-1:0]  id;
        logic [LVL_W-1:0] lvl;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_registers();

        for (int r = 0; r < $size(dir_rows); r++) begin
            send_word(dir_rows[r].kind, dir_rows[r].id, dir_rows[r].level,
                      dir_rows[r].typed, dir_rows[r].res);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                1: load_config($urandom_range(1, 1023), $urandom_range(1, 1023),
                               $urandom_range(1, 1023), $urandom_range(1, 1023),
                               $urandom_range(1, 1023), $urandom_range(1, 16));
                // upper bits of the write must be dropped
                2: load_config(32'hFFFF_FC01, 32'd1, 32'd1, 32'd1, 32'd1, 32'hFFFF_FF01);
                3: begin
                    wait_idle();
                    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
                    load_config($urandom_range(1, 1023), $urandom_range(1, 1023),
                                $urandom_range(1, 1023), $urandom_range(1, 1023),
                                $urandom_range(1, 1023), 32'd0);
                end
                4: load_config(32'd1023, 32'd1023, 32'd1023, 32'd1023, 32'd1023, 32'd255);
                5: load_config($urandom_range(1, 1023), $urandom_range(1, 1023),
                               $urandom_range(1, 1023), $urandom_range(1, 1023),
                               $urandom_range(1, 1023), $urandom_range(1, 255));
                default: ;
            endcase
            if (p == 1) pressure_req = 1;
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                kind = ($urandom_range(0, 99) < ADD_PCT) ? KIND_ADD : KIND_TICK;
                id   = 8'($urandom_range(0, 255));
                lvl  = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7))
                                                    : 3'($urandom_range(0, 4));
                send_word(kind, id, lvl, 1'b0, RES_ZERO);
            end
        end

        wait_idle();
        $display("summary: %0d words in, %0d results, %0d ticks served, %0d flagged",
                 words_in, results_seen, ticks_served, flagged);
        $display("summary: %0d saturated runtimes, queue ended with %0d of %0d tasks",
                 saturated, q_len, MAX_TASKS);
        if (fails == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

[weighted_vruntime_scheduler.f]
+incdir+rtl/core
rtl/core/wvs_pkg.sv
rtl/core/wvs_qmem.sv
rtl/core/wvs_ctrl.sv
rtl/core/weighted_vruntime_scheduler.sv
dv/tb.sv
